// ===== rtl/core/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg
// Operation codes and beat types shared by the three-component vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_DOT       = 4'd3,
    OP_CROSS     = 4'd4,
    OP_LEN_SQ    = 4'd5,
    OP_LENGTH    = 4'd6,
    OP_NORMALIZE = 4'd7,
    OP_LERP      = 4'd8
  } op_t;

  typedef struct packed {
    logic        [3:0]  op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               degenerate;
    logic               overflow;
  } out_t;

endpackage

// ===== rtl/core/v3alu_isqrt.sv =====
// ----------------------------------------------------------------------------
// v3alu_isqrt
// Pipelined integer square root: one result bit per register stage,
// W stages for a 2W-bit radicand.
// ----------------------------------------------------------------------------
module v3alu_isqrt #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic [2*W-1:0]       rad,
  output logic [W-1:0]         root
);

  localparam int SW = 2 * W;
  localparam int RW = SW + 1;

  logic [SW-1:0] n_r   [W];
  logic [RW-1:0] res_r [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [SW-1:0] n_in;
    logic [RW-1:0] res_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] bitv;

    if (k == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign bitv  = RW'(1) << (SW - 2 - 2 * k);
    assign trial = res_in + bitv;

    always_ff @(posedge clk) begin
      if (RW'(n_in) >= trial) begin
        n_r[k]   <= SW'(RW'(n_in) - trial);
        res_r[k] <= (res_in >> 1) + bitv;
      end else begin
        n_r[k]   <= n_in;
        res_r[k] <= res_in >> 1;
      end
    end
  end

  assign root = W'(res_r[W-1]);

endmodule

// ===== rtl/core/v3alu_div.sv =====
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined restoring divider with a short quotient: one quotient bit per
// register stage. The caller guarantees the quotient fits in QB bits.
// ----------------------------------------------------------------------------
module v3alu_div #(
  parameter int W  = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic [W+F+1:0]       num,
  input  logic [W-1:0]         den,
  output logic [F+1:0]         quo
);

  localparam int CW = W + F + 2;
  localparam int QB = F + 2;

  logic [CW-1:0] rem_r [QB];
  logic [W-1:0]  den_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [W-1:0]  den_in;
    logic [QB-1:0] q_in;
    logic [CW-1:0] dsh;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign dsh = CW'(den_in) << (QB - 1 - j);

    always_ff @(posedge clk) begin
      den_r[j] <= den_in;
      if (rem_in >= dsh) begin
        rem_r[j] <= rem_in - dsh;
        q_r[j]   <= q_in | (QB'(1) << (QB - 1 - j));
      end else begin
        rem_r[j] <= rem_in;
        q_r[j]   <= q_in;
      end
    end
  end

  assign quo = q_r[QB-1];

endmodule

// ===== rtl/core/vec3_vector_alu.sv =====
// ----------------------------------------------------------------------------
// vec3_vector_alu
// Three-component fixed-point vector ALU, fully pipelined.
// ----------------------------------------------------------------------------
// The result strobe trails the accepting edge by the full pipeline depth,
// the same for every operation.
// Throughput: one beat per cycle; busy is never raised and nothing stalls.
// Depth is set by the bit-per-stage square root (W stages) and the
// bit-per-stage divider of normalize (F + 2 stages).
// Reset (synchronous, active low) clears only the valid bits.
module vec3_vector_alu
  import v3alu_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * (W + 1);
  localparam int XW = PW + 2;
  localparam int SW = 2 * W;
  localparam int CW = W + F + 2;
  localparam int QB = F + 2;
  localparam int L  = W + 1 + QB;
  localparam int LAT = L + 6;

  localparam logic signed [XW-1:0] ONE_X  = 1;
  localparam logic signed [XW-1:0] WMAX_X = (ONE_X <<< (W - 1)) - ONE_X;
  localparam logic signed [XW-1:0] WMIN_X = -WMAX_X - ONE_X;
  localparam logic signed [XW-1:0] HALF_X = ONE_X <<< (F - 1);

  function automatic logic signed [W-1:0] sat_v(input logic signed [XW-1:0] x);
    if (x > WMAX_X) return W'(WMAX_X);
    if (x < WMIN_X) return W'(WMIN_X);
    return W'(x);
  endfunction

  function automatic logic sat_o(input logic signed [XW-1:0] x);
    return (x > WMAX_X) || (x < WMIN_X);
  endfunction

  assign busy = 1'b0;

  // Stage A: input register.
  logic              va_r;
  op_t               op_a_r;
  logic signed [W-1:0] a_a_r [3];
  logic signed [W-1:0] b_a_r [3];
  logic signed [W-1:0] f_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r   <= op_t'(in_data.op);
    a_a_r[0] <= W'(in_data.ax);
    a_a_r[1] <= W'(in_data.ay);
    a_a_r[2] <= W'(in_data.az);
    b_a_r[0] <= W'(in_data.bx);
    b_a_r[1] <= W'(in_data.by);
    b_a_r[2] <= W'(in_data.bz);
    f_a_r    <= W'(in_data.factor);
  end

  // Stage B: multiplier operand selection.
  logic                vb_r;
  op_t                 op_b_r;
  logic signed [W-1:0] a_b_r [3];
  logic signed [W-1:0] b_b_r [3];
  logic signed [W:0]   mx_r  [6];
  logic signed [W:0]   my_r  [6];
  logic signed [W:0]   mx_nxt [6];
  logic signed [W:0]   my_nxt [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mx_nxt[k] = '0;
      my_nxt[k] = '0;
    end
    case (op_a_r)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = (W+1)'(a_a_r[i]);
          my_nxt[i] = (W+1)'(f_a_r);
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = (W+1)'(a_a_r[i]);
          my_nxt[i] = (W+1)'(b_a_r[i]);
        end
      end
      OP_CROSS: begin
        mx_nxt[0] = (W+1)'(a_a_r[1]); my_nxt[0] = (W+1)'(b_a_r[2]);
        mx_nxt[1] = (W+1)'(a_a_r[2]); my_nxt[1] = (W+1)'(b_a_r[1]);
        mx_nxt[2] = (W+1)'(a_a_r[2]); my_nxt[2] = (W+1)'(b_a_r[0]);
        mx_nxt[3] = (W+1)'(a_a_r[0]); my_nxt[3] = (W+1)'(b_a_r[2]);
        mx_nxt[4] = (W+1)'(a_a_r[0]); my_nxt[4] = (W+1)'(b_a_r[1]);
        mx_nxt[5] = (W+1)'(a_a_r[1]); my_nxt[5] = (W+1)'(b_a_r[0]);
      end
      OP_LEN_SQ, OP_LENGTH, OP_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = (W+1)'(a_a_r[i]);
          my_nxt[i] = (W+1)'(a_a_r[i]);
        end
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          mx_nxt[i] = (W+1)'(b_a_r[i]) - (W+1)'(a_a_r[i]);
          my_nxt[i] = (W+1)'(f_a_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    op_b_r <= op_a_r;
    a_b_r  <= a_a_r;
    b_b_r  <= b_a_r;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
  end

  // Stage C: six multipliers.
  logic                 vc_r;
  op_t                  op_c_r;
  logic signed [W-1:0]  a_c_r [3];
  logic signed [W-1:0]  b_c_r [3];
  logic signed [PW-1:0] p_r   [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    op_c_r <= op_b_r;
    a_c_r  <= a_b_r;
    b_c_r  <= b_b_r;
    for (int k = 0; k < 6; k++) begin
      p_r[k] <= mx_r[k] * my_r[k];
    end
  end

  // Stage D: round products, exact sum of squares for the root.
  logic                 vd_r;
  op_t                  op_d_r;
  logic signed [W-1:0]  a_d_r [3];
  logic signed [W-1:0]  b_d_r [3];
  logic signed [XW-1:0] rn_r  [6];
  logic [SW-1:0]        s_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    op_d_r <= op_c_r;
    a_d_r  <= a_c_r;
    b_d_r  <= b_c_r;
    for (int k = 0; k < 6; k++) begin
      rn_r[k] <= (XW'(p_r[k]) + HALF_X) >>> F;
    end
    s_d_r <= SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]);
  end

  // Stage E (carry line entry 0): combine and saturate.
  logic                 cv_r  [L+1];
  op_t                  cop_r [L+1];
  logic signed [W-1:0]  ca_r  [L+1][3];
  logic signed [W-1:0]  cr_r  [L+1][3];
  logic signed [W-1:0]  csc_r [L+1];
  logic                 cov_r [L+1];
  logic [SW-1:0]        s_e_r;

  logic signed [XW-1:0] xv [3];
  logic signed [XW-1:0] xs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xv[i] = '0;
    end
    xs = '0;
    case (op_d_r)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) xv[i] = XW'(a_d_r[i]) + XW'(b_d_r[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) xv[i] = XW'(a_d_r[i]) - XW'(b_d_r[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) xv[i] = rn_r[i];
      end
      OP_DOT, OP_LEN_SQ: begin
        xs = rn_r[0] + rn_r[1] + rn_r[2];
      end
      OP_CROSS: begin
        xv[0] = rn_r[0] - rn_r[1];
        xv[1] = rn_r[2] - rn_r[3];
        xv[2] = rn_r[4] - rn_r[5];
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++) xv[i] = XW'(a_d_r[i]) + rn_r[i];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    cop_r[0] <= op_d_r;
    for (int i = 0; i < 3; i++) begin
      ca_r[0][i] <= a_d_r[i];
      cr_r[0][i] <= sat_v(xv[i]);
    end
    csc_r[0] <= sat_v(xs);
    cov_r[0] <= sat_o(xv[0]) || sat_o(xv[1]) || sat_o(xv[2]) || sat_o(xs);
    s_e_r    <= s_d_r;
  end

  // Carry line: results of the short operations wait for the root and divider.
  for (genvar k = 0; k < L; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else begin
        cv_r[k+1] <= cv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      cop_r[k+1] <= cop_r[k];
      ca_r[k+1]  <= ca_r[k];
      cr_r[k+1]  <= cr_r[k];
      csc_r[k+1] <= csc_r[k];
      cov_r[k+1] <= cov_r[k];
    end
  end

  // Square root, aligned with carry entry W.
  logic [W-1:0] len_w;

  v3alu_isqrt #(.W(W)) u_isqrt (
    .clk  (clk),
    .rad  (s_e_r),
    .root (len_w)
  );

  // Divider preparation: |a| scaled up, plus half the length for rounding.
  // The magnitude is taken as unsigned so that the most negative value works.
  logic [CW-1:0] num_r  [3];
  logic [W-1:0]  den_r;
  logic [W-1:0]  lend_r [QB+1];
  logic [QB-1:0] quo    [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= (CW'($unsigned(ca_r[W][i][W-1] ? -ca_r[W][i] : ca_r[W][i])) << F)
                + CW'(len_w >> 1);
    end
    den_r     <= len_w;
    lend_r[0] <= len_w;
    for (int j = 0; j < QB; j++) begin
      lend_r[j+1] <= lend_r[j];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo[i])
    );
  end

  // Final stage: merge root and quotient results into the output register.
  logic                 out_valid_r;
  logic signed [W-1:0]  fr_nxt [3];
  logic signed [W-1:0]  fsc_nxt;
  logic                 fov_nxt;
  logic                 fdeg_nxt;
  logic signed [W-1:0]  fr_r [3];
  logic signed [W-1:0]  fsc_r;
  logic                 fov_r;
  logic                 fdeg_r;
  logic signed [XW-1:0] xl;
  logic signed [XW-1:0] xq [3];

  always_comb begin
    fr_nxt   = cr_r[L];
    fsc_nxt  = csc_r[L];
    fov_nxt  = cov_r[L];
    fdeg_nxt = 1'b0;
    xl       = XW'({1'b0, lend_r[QB]});
    for (int i = 0; i < 3; i++) begin
      xq[i] = XW'({1'b0, quo[i]});
      if (ca_r[L][i][W-1]) xq[i] = -xq[i];
    end
    case (cop_r[L])
      OP_LENGTH: begin
        fsc_nxt = sat_v(xl);
        fov_nxt = sat_o(xl);
      end
      OP_NORMALIZE: begin
        if (lend_r[QB] == '0) begin
          fdeg_nxt = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            fr_nxt[i] = sat_v(xq[i]);
          end
          fov_nxt = sat_o(xq[0]) || sat_o(xq[1]) || sat_o(xq[2]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv_r[L];
    end
  end

  always_ff @(posedge clk) begin
    fr_r   <= fr_nxt;
    fsc_r  <= fsc_nxt;
    fov_r  <= fov_nxt;
    fdeg_r <= fdeg_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_data.rx         = 32'(fr_r[0]);
  assign out_data.ry         = 32'(fr_r[1]);
  assign out_data.rz         = 32'(fr_r[2]);
  assign out_data.scalar_out = 32'(fsc_r);
  assign out_data.degenerate = fdeg_r;
  assign out_data.overflow   = fov_r;

`ifndef SYNTH
  // Every accepted beat produces its strobe after the fixed pipeline depth.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing after pipeline latency");

  // A degenerate normalize yields an all-zero result and never saturates.
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.rx == 0 && out_data.ry == 0 && out_data.rz == 0 &&
       out_data.scalar_out == 0 && !out_data.overflow))
    else $error("degenerate result is not the zero vector");

  // The carry line and the output strobe stay in step.
  a_strobe_align : assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[L] |=> out_valid)
    else $error("output strobe lost at the final stage");
`endif

endmodule

// ===== dv/vec3_vector_alu_checker.sv =====
// ----------------------------------------------------------------------------
// vec3_vector_alu_checker
// Watches the command and result beats of the vector ALU, computes the
// expected result of every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module vec3_vector_alu_checker
  import v3alu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  out_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic longint round_frac(longint p);
    return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    return round_frac(a * b);
  endfunction

  function automatic longint clamp(longint x, ref bit ovf);
    if (x > WMAX) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      ovf = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + longint'(den) / 2) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_t alu_result(in_t cmd);
    longint a[3];
    longint b[3];
    longint r[3];
    longint sc;
    longint f;
    longint unsigned sumsq;
    longint len;
    bit ovf;
    bit deg;
    out_t res;
    a[0] = cmd.ax; a[1] = cmd.ay; a[2] = cmd.az;
    b[0] = cmd.bx; b[1] = cmd.by; b[2] = cmd.bz;
    f = cmd.factor;
    r[0] = 0; r[1] = 0; r[2] = 0;
    sc = 0;
    ovf = 0;
    deg = 0;
    case (cmd.op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], ovf);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], ovf);
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp(mul_round(a[i], f), ovf);
      OP_DOT: sc = clamp(mul_round(a[0], b[0]) + mul_round(a[1], b[1])
                         + mul_round(a[2], b[2]), ovf);
      OP_CROSS: begin
        r[0] = clamp(mul_round(a[1], b[2]) - mul_round(a[2], b[1]), ovf);
        r[1] = clamp(mul_round(a[2], b[0]) - mul_round(a[0], b[2]), ovf);
        r[2] = clamp(mul_round(a[0], b[1]) - mul_round(a[1], b[0]), ovf);
      end
      OP_LEN_SQ: sc = clamp(mul_round(a[0], a[0]) + mul_round(a[1], a[1])
                            + mul_round(a[2], a[2]), ovf);
      OP_LENGTH, OP_NORMALIZE: begin
        // Each square is at most 2^62, so the sum of three stays unsigned 64-bit.
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq = sumsq + longint'(a[i] * a[i]);
        len = int_sqrt(sumsq);
        if (cmd.op == OP_LENGTH) begin
          sc = clamp(len, ovf);
        end else if (len == 0) begin
          deg = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++)
            r[i] = clamp(div_nearest(a[i] <<< FRAC, len), ovf);
        end
      end
      OP_LERP: for (int i = 0; i < 3; i++)
        r[i] = clamp(a[i] + round_frac((b[i] - a[i]) * f), ovf);
      default: ;
    endcase
    res.rx = r[0][31:0];
    res.ry = r[1][31:0];
    res.rz = r[2][31:0];
    res.scalar_out = sc[31:0];
    res.degenerate = deg;
    res.overflow = ovf;
    return res;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    out_t exp_beat;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        fail_count <= fail_count + 1;
      end else begin
        exp_beat = expected_q.pop_front();
        if (exp_beat !== out_data) begin
          $display("%0t: mismatch expected rx=%h ry=%h rz=%h sc=%h deg=%b ovf=%b",
                   $time, exp_beat.rx, exp_beat.ry, exp_beat.rz,
                   exp_beat.scalar_out, exp_beat.degenerate, exp_beat.overflow);
          $display("%0t:          actual   rx=%h ry=%h rz=%h sc=%h deg=%b ovf=%b",
                   $time, out_data.rx, out_data.ry, out_data.rz,
                   out_data.scalar_out, out_data.degenerate, out_data.overflow);
          fail_count <= fail_count + 1;
        end
      end
    end
    if (rst_n && start && !busy) expected_q.push_back(alu_result(in_data));
  end
endmodule

// ===== dv/vec3_vector_alu_test.sv =====
// ----------------------------------------------------------------------------
// vec3_vector_alu_test
// Drives directed and random vector commands with random idle bursts into
// the vector ALU; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module vec3_vector_alu_test
  import v3alu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1350;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending_count;
  int   op_seen[16];

  vec3_vector_alu u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  vec3_vector_alu_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("vec3_vector_alu test failed");
    $finish;
  end

  // Mixes extremes, small values and full-range noise.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      4, 5: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      6: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom();
    endcase
  endfunction

  // Sends one beat and, when idles are allowed, sometimes idles before the next.
  task automatic send_beat(in_t cmd, bit allow_idle);
    int gap;
    in_data <= cmd;
    start <= 1'b1;
    op_seen[cmd.op]++;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      in_data <= in_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom()});
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_vec(logic [3:0] op, logic [31:0] x0, logic [31:0] y0,
                          logic [31:0] z0, logic [31:0] x1, logic [31:0] y1,
                          logic [31:0] z1, logic [31:0] f, bit allow_idle);
    in_t cmd;
    cmd = '{op: op, ax: x0, ay: y0, az: z0, bx: x1, by: y1, bz: z1, factor: f};
    send_beat(cmd, allow_idle);
  endtask

  initial begin
    in_t cmd;
    int cycles;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: extremes, every op, zero-length normalize, unused codes.
    send_vec(OP_ADD, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000,
             0, 0, 1);
    send_vec(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h10000, 32'h7fffffff,
             32'h80000000, 32'h10000, 0, 1);
    send_vec(OP_SCALE, 32'h7fffffff, 32'h80000000, 32'h18000, 0, 0, 0,
             32'h7fffffff, 1);
    send_vec(OP_SCALE, 32'h10000, 32'hffff8000, 32'h8000, 0, 0, 0, 32'h8000, 1);
    send_vec(OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 0, 1);
    send_vec(OP_DOT, 32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000,
             32'h60000, 0, 1);
    send_vec(OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 1);
    send_vec(OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, 0, 1);
    send_vec(OP_LEN_SQ, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 1);
    send_vec(OP_LEN_SQ, 32'h30000, 32'h40000, 0, 0, 0, 0, 0, 1);
    send_vec(OP_LENGTH, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 1);
    send_vec(OP_LENGTH, 32'h30000, 32'h40000, 0, 0, 0, 0, 0, 1);
    send_vec(OP_LENGTH, 0, 0, 0, 0, 0, 0, 0, 1);
    send_vec(OP_NORMALIZE, 0, 0, 0, 1, 2, 3, 4, 1);
    send_vec(OP_NORMALIZE, 32'h30000, 32'hfffc0000, 0, 0, 0, 0, 0, 1);
    send_vec(OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 1);
    send_vec(OP_NORMALIZE, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 1);
    send_vec(OP_LERP, 0, 32'h10000, 32'h80000000, 32'h10000, 32'h30000,
             32'h7fffffff, 32'h8000, 1);
    send_vec(OP_LERP, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
             0, 32'h7fffffff, 1);
    send_vec(OP_LERP, 32'h10000, 32'h20000, 32'h30000, 32'h50000, 32'h60000,
             32'h70000, 32'h80000000, 1);
    send_vec(4'd9, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
    send_vec(4'd15, 1, 2, 3, 4, 5, 6, 7, 1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 19) == 0) cmd.op = 4'($urandom_range(9, 15));
      else cmd.op = 4'($urandom_range(0, 8));
      cmd.ax = pick_value(); cmd.ay = pick_value(); cmd.az = pick_value();
      cmd.bx = pick_value(); cmd.by = pick_value(); cmd.bz = pick_value();
      cmd.factor = pick_value();
      // The last stretch runs back to back with no idle cycles.
      send_beat(cmd, n < NUM_RANDOM - 200);
    end
    start <= 1'b0;

    cycles = 0;
    while (pending_count != 0 && cycles < 10000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d directed and %0d random beats, ops 0..8 seen %0d..%0d times.",
             22, NUM_RANDOM, op_seen[OP_ADD], op_seen[OP_LERP]);
    if (fail_count == 0 && pending_count == 0) begin
      $display("vec3_vector_alu test passed");
    end else begin
      $display("vec3_vector_alu test failed");
    end
    $finish;
  end
endmodule
